[src/chained_hash_set_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hash set unit
// Immediate-implication and next-cycle checks, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_SET_UNIT_MACROS_SVH
`define CHAINED_HASH_SET_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define CHS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hash set check failed");

// Consequent must hold in the cycle after the antecedent
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hash set check failed");

`else

`define CHS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/chs_pkg.sv]
// ----------------------------------------------------------------------------
// Hash set package
// Shared constants, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int BUCKETS_DEF     = 5;
	localparam int CHAIN_DEPTH_DEF = 8;

	localparam int OP_W      = 2;
	localparam int KEY_W     = 31;
	localparam int ST_W      = 3;
	localparam int BKT_OUT_W = 3;

	// key is reduced modulo the bucket count one 8-bit digit per cycle
	localparam int DIGIT_W   = 8;
	localparam int MOD_STEPS = 4;
	localparam int MOD_CNT_W = 2;
	localparam int SH_W      = DIGIT_W * MOD_STEPS;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} st_code_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_ROW,
		S_DECIDE,
		S_WALK,
		S_WRITE,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic     clr;
		logic     load;
		logic     mod_step;
		logic     row_rd;
		logic     walk_start;
		logic     walk_issue;
		logic     sel_free;
		logic     sel_hit;
		logic     wr_key;
		logic     wr_row;
		logic     out_load;
		st_code_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_done;
		logic is_insert;
		logic is_delete;
		logic row_full;
		logic hit;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

[src/chs_datapath.sv]
// ----------------------------------------------------------------------------
// Hash set datapath
// Modulo unit, bucket valid-row memory, key memory with chain walk compare,
// and the result register.
// ----------------------------------------------------------------------------
module chs_datapath #(
	parameter int BUCKETS     = chs_pkg::BUCKETS_DEF,
	parameter int CHAIN_DEPTH = chs_pkg::CHAIN_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [chs_pkg::OP_W-1:0]          operation,
	input  logic [chs_pkg::KEY_W-1:0]         key,
	input  logic                              out_stall,
	input  chs_pkg::dp_cmd_t                  cmd,
	output chs_pkg::dp_stat_t                 st,
	output logic                              out_valid,
	output logic [chs_pkg::ST_W-1:0]          status,
	output logic [chs_pkg::BKT_OUT_W-1:0]     bucket
);
	import chs_pkg::*;

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int SLOT_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int TOTAL  = BUCKETS * CHAIN_DEPTH;
	localparam int ADDR_W = $clog2(TOTAL);
	localparam logic [BKT_W:0] BKT_LIM = (BKT_W+1)'(BUCKETS);

	logic [OP_W-1:0]        op_q;
	logic [KEY_W-1:0]       key_q;
	logic [SH_W-1:0]        sh_q;
	logic [BKT_W-1:0]       rem_q;
	logic [BKT_W-1:0]       rem_d;
	logic [MOD_CNT_W-1:0]   mod_cnt_q;
	logic [BKT_W-1:0]       clr_cnt_q;
	logic [ADDR_W-1:0]      base_q;
	logic [CHAIN_DEPTH-1:0] row_q;
	logic [CHAIN_DEPTH-1:0] row_new;
	logic [CHAIN_DEPTH-1:0] slot_mask;
	logic [SLOT_W-1:0]      free_slot;
	logic [SLOT_W-1:0]      slot_sel_q;
	logic [SLOT_W-1:0]      issue_q;
	logic                   issued_all_q;
	logic                   rd_en;
	logic [ADDR_W-1:0]      kaddr;
	logic [BKT_W-1:0]       vaddr;
	logic                   cmp_v_s1;
	logic [SLOT_W-1:0]      cmp_slot_s1;
	logic [KEY_W-1:0]       kdata_s1;
	logic                   out_valid_q;
	st_code_t               status_q;
	logic [BKT_OUT_W-1:0]   bucket_q;

	logic [KEY_W-1:0]       kmem [TOTAL];
	logic [CHAIN_DEPTH-1:0] vmem [BUCKETS];

	// Reduce one digit of the key: shift in bit by bit, subtract when over
	always_comb begin
		logic [BKT_W:0]   t;
		logic [BKT_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {r, sh_q[SH_W-1-i]};
			if (t >= BKT_LIM) begin
				t = t - BKT_LIM;
			end
			r = t[BKT_W-1:0];
		end
		rem_d = r;
	end

	// Lowest free slot of the bucket row
	always_comb begin
		free_slot = '0;
		for (int i = CHAIN_DEPTH - 1; i >= 0; i--) begin
			if (!row_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end

	// Updated valid row: set the chosen slot on insert, clear it on delete
	assign slot_mask = CHAIN_DEPTH'(1) << slot_sel_q;
	assign row_new   = (op_q == OP_INSERT) ? (row_q | slot_mask) : (row_q & ~slot_mask);

	assign rd_en = cmd.walk_issue && !issued_all_q;
	assign kaddr = cmd.wr_key ? (base_q + ADDR_W'(slot_sel_q)) : (base_q + ADDR_W'(issue_q));
	assign vaddr = cmd.clr ? clr_cnt_q : rem_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_cnt_q    <= '0;
			clr_cnt_q    <= '0;
			issued_all_q <= 1'b0;
			cmp_v_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.load) begin
				mod_cnt_q <= '0;
			end else if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end
			if (cmd.walk_start) begin
				issued_all_q <= 1'b0;
				cmp_v_s1     <= 1'b0;
			end else begin
				cmp_v_s1 <= rd_en;
				if (rd_en && issue_q == SLOT_W'(CHAIN_DEPTH - 1)) begin
					issued_all_q <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key;
			sh_q  <= {1'b0, key};
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			sh_q  <= sh_q << DIGIT_W;
			rem_q <= rem_d;
		end
		if (cmd.row_rd) begin
			base_q <= ADDR_W'(32'(rem_q) * CHAIN_DEPTH);
		end
		if (cmd.walk_start) begin
			issue_q <= '0;
		end else if (rd_en) begin
			issue_q <= issue_q + 1'b1;
		end
		cmp_slot_s1 <= issue_q;
		if (cmd.sel_free) begin
			slot_sel_q <= free_slot;
		end else if (cmd.sel_hit) begin
			slot_sel_q <= cmp_slot_s1;
		end
		if (cmd.out_load) begin
			status_q <= cmd.code;
			bucket_q <= BKT_OUT_W'(rem_q);
		end
	end

	// Key memory: one port, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_key) begin
			kmem[kaddr] <= key_q;
		end else if (rd_en) begin
			kdata_s1 <= kmem[kaddr];
		end
	end

	// Valid-row memory: one row per bucket, swept to zero after reset
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			vmem[vaddr] <= '0;
		end else if (cmd.wr_row) begin
			vmem[vaddr] <= row_new;
		end else if (cmd.row_rd) begin
			row_q <= vmem[vaddr];
		end
	end

	// Status towards the controller
	always_comb begin
		st.clr_last  = (clr_cnt_q == BKT_W'(BUCKETS - 1));
		st.mod_done  = (mod_cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
		st.is_insert = (op_q == OP_INSERT);
		st.is_delete = (op_q == OP_DELETE);
		st.row_full  = &row_q;
		st.hit       = cmp_v_s1 && row_q[cmp_slot_s1] && (kdata_s1 == key_q);
		st.last      = cmp_v_s1 && (cmp_slot_s1 == SLOT_W'(CHAIN_DEPTH - 1));
		st.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bucket    = bucket_q;

endmodule

[src/chs_ctrl.sv]
// ----------------------------------------------------------------------------
// Hash set controller
// Sequences clearing, modulo, row read, chain walk, write-back and result.
// ----------------------------------------------------------------------------
module chs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  chs_pkg::dp_stat_t st,
	output chs_pkg::dp_cmd_t  cmd
);
	import chs_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	st_code_t   code_q;
	st_code_t   code_d;

	// Hold state and result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			code_q  <= ST_NOT_FOUND;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_MOD;
			end
			S_MOD: begin
				if (st.mod_done) state_d = S_ROW;
			end
			S_ROW: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!st.is_insert) begin
					state_d = S_WALK;
				end else if (st.row_full) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WALK: begin
				if (st.hit) begin
					state_d = st.is_delete ? S_WRITE : S_DONE;
				end else if (st.last) begin
					state_d = S_DONE;
				end
			end
			S_WRITE: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Commands and result code
	always_comb begin
		cmd      = '0;
		code_d   = code_q;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
			end
			S_ROW: begin
				cmd.row_rd = 1'b1;
			end
			S_DECIDE: begin
				if (!st.is_insert) begin
					cmd.walk_start = 1'b1;
				end else if (st.row_full) begin
					code_d = ST_FULL;
				end else begin
					cmd.sel_free = 1'b1;
					code_d       = ST_INSERTED;
				end
			end
			S_WALK: begin
				cmd.walk_issue = 1'b1;
				if (st.hit) begin
					if (st.is_delete) begin
						cmd.sel_hit = 1'b1;
						code_d      = ST_DELETED;
					end else begin
						code_d = ST_FOUND;
					end
				end else if (st.last) begin
					code_d = ST_NOT_FOUND;
				end
			end
			S_WRITE: begin
				cmd.wr_row = 1'b1;
				cmd.wr_key = st.is_insert;
			end
			S_DONE: begin
				cmd.out_load = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
		cmd.code = code_q;
	end

endmodule

[src/chained_hash_set_unit.sv]
// ----------------------------------------------------------------------------
// Chained hash set unit
// Bounded separate-chaining set of 31-bit keys with insert, delete, search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one operation and key per
//   transfer; output channel (out_valid/out_stall) returns one status and
//   bucket index per item, in order.
//   The key is reduced modulo BUCKETS one 8-bit digit per cycle, the
//   bucket's valid row is read next, and delete/search then read one key
//   per cycle through the single key-memory port.
//   The unit takes one item at a time.
//   After reset the unit stalls its input while it sweeps the valid rows
//   to zero.
//   A finished result waits in the output register while out_stall is high;
//   the unit accepts the next item once the result is taken, or while it is
//   still pending but already loaded.
// ----------------------------------------------------------------------------
`include "chained_hash_set_unit_macros.svh"

module chained_hash_set_unit #(
	parameter int BUCKETS     = chs_pkg::BUCKETS_DEF,
	parameter int CHAIN_DEPTH = chs_pkg::CHAIN_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [chs_pkg::OP_W-1:0]      operation,
	input  logic [chs_pkg::KEY_W-1:0]     key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [chs_pkg::ST_W-1:0]      status,
	output logic [chs_pkg::BKT_OUT_W-1:0] bucket
);
	import chs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	// Sequencer
	chs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Storage and arithmetic
	chs_datapath #(
		.BUCKETS     (BUCKETS),
		.CHAIN_DEPTH (CHAIN_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.operation (operation),
		.key       (key),
		.out_stall (out_stall),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.status    (status),
		.bucket    (bucket)
	);

	// An accepted item keeps the input stalled in the next cycle
	`CHS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// A new result never overwrites one that is still held
	`CHS_ASSERT_SAME(a_no_result_overwrite, clk, arst_n, cmd.out_load, !out_valid || !out_stall)
	// A key write always comes with its valid-row update
	`CHS_ASSERT_SAME(a_key_with_row, clk, arst_n, cmd.wr_key, cmd.wr_row)

endmodule
